>>> rtl/glu_pkg.sv
package glu_pkg;

  localparam int unsigned OpW = 32;
  localparam int unsigned InW = 32;
  localparam int unsigned OutW = 64;

  localparam int unsigned KW = $clog2(OpW);
  localparam int unsigned CntW = $clog2(OpW);

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW = $clog2(QDepth);

  typedef struct packed {
    logic [OpW-1:0] a;
    logic [OpW-1:0] b;
    logic           zero;
  } q_entry_t;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StGcd  = 4'b0010,
    StDiv  = 4'b0100,
    StMul  = 4'b1000
  } back_state_e;

endpackage

>>> rtl/glu_if.sv
interface glu_req_if;
  import glu_pkg::*;

  logic           valid;
  logic           ready;
  logic [InW-1:0] first_operand;
  logic [InW-1:0] second_operand;

  modport source (output valid, output first_operand, output second_operand, input ready);
  modport sink (input valid, input first_operand, input second_operand, output ready);
endinterface

interface glu_rsp_if;
  import glu_pkg::*;

  logic            valid;
  logic            ready;
  logic [InW-1:0]  divisor_result;
  logic [OutW-1:0] multiple_result;

  modport source (output valid, output divisor_result, output multiple_result, input ready);
  modport sink (input valid, input divisor_result, input multiple_result, output ready);
endinterface

>>> rtl/glu_front.sv
module glu_front
  import glu_pkg::*;
(
  glu_req_if.sink  req_i,
  input  logic     full_i,
  output logic     push_o,
  output q_entry_t push_data_o
);

  logic [OpW-1:0] a;
  logic [OpW-1:0] b;

  assign a = req_i.first_operand[OpW-1:0];
  assign b = req_i.second_operand[OpW-1:0];

  assign req_i.ready = !full_i;
  assign push_o = req_i.valid && !full_i;

  // A zero operand needs no iteration: the gcd is the other operand and the lcm is zero.
  always_comb begin
    push_data_o.a = a;
    push_data_o.b = b;
    push_data_o.zero = (a == '0) || (b == '0);
  end

endmodule

>>> rtl/glu_fifo.sv
module glu_fifo
  import glu_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t push_data_i,
  output logic     full_o,
  input  logic     pop_i,
  output q_entry_t pop_data_o,
  output logic     empty_o
);

  q_entry_t             mem_q [QDepth];
  logic [QPtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [QPtrW:0]       cnt_q, cnt_d;

  assign full_o = (cnt_q == (QPtrW+1)'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/glu_back.sv
module glu_back
  import glu_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     empty_i,
  input  q_entry_t pop_data_i,
  output logic     pop_o,
  glu_rsp_if.source rsp_o
);

  back_state_e       state_q, state_d;
  logic              vld_q, vld_d;
  logic [OpW-1:0]    a_q, a_d;
  logic [OpW-1:0]    b_q, b_d;
  logic [OpW-1:0]    x_q, x_d;
  logic [OpW-1:0]    y_q, y_d;
  logic [KW-1:0]     k_q, k_d;
  logic [OpW-1:0]    g_q, g_d;
  logic [OpW-1:0]    dq_q, dq_d;
  logic [OpW-1:0]    rem_q, rem_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [InW-1:0]    div_res_q, div_res_d;
  logic [OutW-1:0]   mul_res_q, mul_res_d;
  logic [OpW:0]      trial;
  logic [OpW:0]      diff;
  logic [2*OpW-1:0]  prod;

  assign trial = {rem_q, dq_q[OpW-1]};
  assign diff = trial - {1'b0, g_q};
  assign prod = dq_q * b_q;

  assign rsp_o.valid = vld_q;
  assign rsp_o.divisor_result = div_res_q;
  assign rsp_o.multiple_result = mul_res_q;

  always_comb begin
    state_d = state_q;
    vld_d = vld_q;
    a_d = a_q;
    b_d = b_q;
    x_d = x_q;
    y_d = y_q;
    k_d = k_q;
    g_d = g_q;
    dq_d = dq_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    div_res_d = div_res_q;
    mul_res_d = mul_res_q;
    pop_o = 1'b0;

    if (rsp_o.ready) begin
      vld_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          a_d = pop_data_i.a;
          b_d = pop_data_i.b;
          x_d = pop_data_i.a;
          y_d = pop_data_i.b;
          k_d = '0;
          if (pop_data_i.zero) begin
            g_d = pop_data_i.a | pop_data_i.b;
            dq_d = '0;
            state_d = StMul;
          end else begin
            state_d = StGcd;
          end
        end
      end
      StGcd: begin
        // Binary gcd: strip common factors of two, halve a lone even operand, then subtract odd from odd and halve.
        priority if ((x_q == '0) || (y_q == '0)) begin
          g_d = (x_q | y_q) << k_q;
          dq_d = a_q;
          rem_d = '0;
          cnt_d = '0;
          state_d = StDiv;
        end else if (!x_q[0] && !y_q[0]) begin
          x_d = x_q >> 1;
          y_d = y_q >> 1;
          k_d = k_q + 1'b1;
        end else if (!x_q[0]) begin
          x_d = x_q >> 1;
        end else if (!y_q[0]) begin
          y_d = y_q >> 1;
        end else if (x_q >= y_q) begin
          x_d = (x_q - y_q) >> 1;
        end else begin
          y_d = (y_q - x_q) >> 1;
        end
      end
      StDiv: begin
        // Restoring division of the first operand by the gcd, one quotient bit per cycle.
        if (!diff[OpW]) begin
          rem_d = diff[OpW-1:0];
          dq_d = {dq_q[OpW-2:0], 1'b1};
        end else begin
          rem_d = trial[OpW-1:0];
          dq_d = {dq_q[OpW-2:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(OpW - 1)) begin
          state_d = StMul;
        end
      end
      StMul: begin
        if (!vld_q || rsp_o.ready) begin
          div_res_d = InW'(g_q);
          mul_res_d = OutW'(prod);
          vld_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    x_q <= x_d;
    y_q <= y_d;
    k_q <= k_d;
    g_q <= g_d;
    dq_q <= dq_d;
    rem_q <= rem_d;
    cnt_q <= cnt_d;
    div_res_q <= div_res_d;
    mul_res_q <= mul_res_d;
  end

endmodule

>>> rtl/gcd_lcm_unit_core.sv
// Computes the greatest common divisor and the least common multiple of two unsigned
// operands, one request at a time. A binary gcd loop runs halving and subtraction steps,
// a bit-serial divider then forms the first operand over the gcd one quotient bit at a
// time, and a multiply step gives the lcm as that quotient times the second operand. A
// request with a zero operand skips the loop and the divider. A two-entry queue in front
// of the arithmetic keeps accepting requests while it works, until it is full, and an
// output register holds a finished result until it is taken. A gcd of zero is returned
// only when both operands are zero, and the lcm is zero whenever either operand is zero.
module gcd_lcm_unit_core
  import glu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  glu_req_if.sink   req_i,
  glu_rsp_if.source rsp_o
);

  logic     push;
  logic     full;
  logic     pop;
  logic     empty;
  q_entry_t push_data;
  q_entry_t pop_data;

  glu_front u_front (
    .req_i       (req_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  glu_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  glu_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .pop_data_i (pop_data),
    .pop_o      (pop),
    .rsp_o      (rsp_o)
  );

endmodule

>>> rtl/glu_checker.sv
module glu_checker
  import glu_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            req_valid_i,
  input logic            req_ready_i,
  input logic            rsp_valid_i,
  input logic            rsp_ready_i,
  input logic [InW-1:0]  rsp_divisor_i,
  input logic [OutW-1:0] rsp_multiple_i
);

  logic [3:0] open_q;
  logic       req_fire;
  logic       rsp_fire;

  assign req_fire = req_valid_i && req_ready_i;
  assign rsp_fire = rsp_valid_i && rsp_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else if (req_fire && !rsp_fire) begin
      open_q <= open_q + 1'b1;
    end else if (rsp_fire && !req_fire) begin
      open_q <= open_q - 1'b1;
    end
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_divisor_i)
      && $stable(rsp_multiple_i))
    else $error("Response changed while stalled.");

  a_no_orphan_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> open_q != '0)
    else $error("Response without an outstanding request.");

  a_zero_gcd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_divisor_i == '0 |-> rsp_multiple_i == '0)
    else $error("Zero gcd with nonzero lcm.");

  a_lcm_ge_gcd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_multiple_i != '0 |-> rsp_multiple_i >= OutW'(rsp_divisor_i))
    else $error("Nonzero lcm below gcd.");

endmodule

bind gcd_lcm_unit_core glu_checker u_glu_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .rsp_divisor_i  (rsp_o.divisor_result),
  .rsp_multiple_i (rsp_o.multiple_result)
);
